/* rtl/core/ght_pkg.sv */
`timescale 1ns / 1ps

package ght_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_STALE = 2'd2;

    typedef logic [2:0] step_t;

    localparam step_t STEP_END  = 3'd0;
    localparam step_t STEP_ADD0 = 3'd1;
    localparam step_t STEP_ADD1 = 3'd2;
    localparam step_t STEP_REM0 = 3'd3;
    localparam step_t STEP_REM1 = 3'd4;
    localparam step_t STEP_REM2 = 3'd5;
    localparam step_t STEP_QRY0 = 3'd6;
    localparam step_t STEP_QRY1 = 3'd7;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TAKE,
        OP_ADD,
        OP_REM
    } op_t;

    typedef enum logic {
        SA_HANDLE,
        SA_FREE
    } rd_sel_t;

    typedef enum logic [2:0] {
        RS_KEEP,
        RS_FULL_CHK,
        RS_ADD,
        RS_BAD_CHK,
        RS_REM,
        RS_QRY
    } res_sel_t;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_FULL,
        JC_BAD
    } jump_cond_t;

    typedef struct packed {
        op_t        op;
        rd_sel_t    rd_sel;
        res_sel_t   res_sel;
        jump_cond_t jump;
        step_t      target;
        logic       done;
    } ctrl_t;

    typedef struct packed {
        logic full;
        logic bad;
        logic clearing;
    } dp_flags_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    localparam ctrl_t CTRL_NOP = '{
        op:      OP_NONE,
        rd_sel:  SA_HANDLE,
        res_sel: RS_KEEP,
        jump:    JC_NEXT,
        target:  STEP_END,
        done:    1'b0
    };

    // The control store: one word for each step of the program.
    function automatic ctrl_t ght_rom(input step_t step);
        ctrl_t w;
        w = CTRL_NOP;
        unique case (step)
            STEP_END:
            begin
                w.done = 1'b1;
            end
            STEP_ADD0:
            begin
                w.rd_sel  = SA_FREE;
                w.res_sel = RS_FULL_CHK;
                w.jump    = JC_FULL;
                w.target  = STEP_END;
            end
            STEP_ADD1:
            begin
                w.op      = OP_ADD;
                w.res_sel = RS_ADD;
                w.jump    = JC_ALWAYS;
                w.target  = STEP_END;
            end
            STEP_REM0:
            begin
                w.rd_sel = SA_HANDLE;
            end
            STEP_REM1:
            begin
                w.op      = OP_TAKE;
                w.res_sel = RS_BAD_CHK;
                w.jump    = JC_BAD;
                w.target  = STEP_END;
            end
            STEP_REM2:
            begin
                w.op      = OP_REM;
                w.res_sel = RS_REM;
                w.jump    = JC_ALWAYS;
                w.target  = STEP_END;
            end
            STEP_QRY0:
            begin
                w.rd_sel = SA_HANDLE;
            end
            STEP_QRY1:
            begin
                w.res_sel = RS_QRY;
                w.jump    = JC_ALWAYS;
                w.target  = STEP_END;
            end
            default:
            begin
                w = CTRL_NOP;
            end
        endcase
        return w;
    endfunction

    // First step of the routine for each command.
    function automatic step_t ght_entry(input logic [1:0] command);
        step_t s;
        s = STEP_END;
        unique case (command)
            CMD_ADD:    s = STEP_ADD0;
            CMD_REMOVE: s = STEP_REM0;
            CMD_QUERY:  s = STEP_QRY0;
            default:    s = STEP_END;
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/generational_handle_table.sv */
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// command   cmd_valid / cmd_stall     command, handle_slot, handle_generation
// result    res_valid / res_stall     new_slot, new_generation, dense_position,
//                                     present, status, live_total
//
// The control program works one item at a time, one step per cycle. An add ends
// early when full and a remove when stale; the unused code ends at once. An item
// can be accepted in the cycle after the previous result is registered. After reset a
// clearing pass walks the slot stores, and no item is accepted until it ends.
// While a result waits under res_stall the next item can be worked, but it holds
// at its last step and nothing more is accepted until then.

module generational_handle_table
#(
    parameter int SLOTS           = 256,
    parameter int GENERATION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  handle_slot,
    input  logic [15:0] handle_generation,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  new_slot,
    output logic [15:0] new_generation,
    output logic [7:0]  dense_position,
    output logic        present,
    output logic [1:0]  status,
    output logic [8:0]  live_total
);

    localparam int CW = $clog2(SLOTS + 1);

    ght_pkg::ctrl_t     ctrl;
    ght_pkg::dp_flags_t flags;
    logic               accept;
    logic               busy;
    logic               done_fire;
    logic               out_free;
    logic [7:0]         dp_slot;
    logic [15:0]        dp_generation;
    logic [7:0]         dp_position;
    logic               dp_present;
    logic [1:0]         dp_status;
    logic [CW-1:0]      dp_live_count;
    logic [31:0]        live_wide;

    logic               res_valid_reg;
    logic               res_valid_next;
    logic [7:0]         new_slot_reg;
    logic [15:0]        new_generation_reg;
    logic [7:0]         dense_position_reg;
    logic               present_reg;
    logic [1:0]         status_reg;
    logic [8:0]         live_total_reg;

    assign cmd_stall = busy;
    assign accept    = cmd_valid & ~busy;
    assign out_free  = ~res_valid_reg | ~res_stall;
    assign live_wide = 32'(dp_live_count);

    ght_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .flags     (flags),
        .out_free  (out_free),
        .ctrl      (ctrl),
        .busy      (busy),
        .done_fire (done_fire)
    );

    ght_datapath
    #(
        .SLOTS           (SLOTS),
        .GENERATION_BITS (GENERATION_BITS)
    )
    u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (accept),
        .handle_slot       (handle_slot),
        .handle_generation (handle_generation),
        .ctrl              (ctrl),
        .flags             (flags),
        .res_slot          (dp_slot),
        .res_generation    (dp_generation),
        .res_position      (dp_position),
        .res_present       (dp_present),
        .res_status        (dp_status),
        .live_count        (dp_live_count)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (done_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (~res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            new_slot_reg       <= dp_slot;
            new_generation_reg <= dp_generation;
            dense_position_reg <= dp_position;
            present_reg        <= dp_present;
            status_reg         <= dp_status;
            live_total_reg     <= live_wide[8:0];
        end
    end

    assign res_valid      = res_valid_reg;
    assign new_slot       = new_slot_reg;
    assign new_generation = new_generation_reg;
    assign dense_position = dense_position_reg;
    assign present        = present_reg;
    assign status         = status_reg;
    assign live_total     = live_total_reg;

endmodule

/* rtl/core/ght_seq.sv */
`timescale 1ns / 1ps

module ght_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        command,
    input  ght_pkg::dp_flags_t flags,
    input  logic              out_free,
    output ght_pkg::ctrl_t    ctrl,
    output logic              busy,
    output logic              done_fire
);

    ght_pkg::seq_state_t state_reg;
    ght_pkg::seq_state_t state_next;
    ght_pkg::step_t      step_reg;
    ght_pkg::step_t      step_next;
    ght_pkg::ctrl_t      word;
    logic                take_jump;

    assign word = ght_pkg::ght_rom(step_reg);

    always_comb
    begin
        case (word.jump)
            ght_pkg::JC_ALWAYS: take_jump = 1'b1;
            ght_pkg::JC_FULL:   take_jump = flags.full;
            ght_pkg::JC_BAD:    take_jump = flags.bad;
            default:            take_jump = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ght_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = ght_pkg::SEQ_RUN;
                    step_next  = ght_pkg::ght_entry(command);
                end
            end
            ght_pkg::SEQ_RUN:
            begin
                if (word.done)
                begin
                    if (out_free)
                    begin
                        state_next = ght_pkg::SEQ_IDLE;
                    end
                end
                else if (take_jump)
                begin
                    step_next = word.target;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ght_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl      = ght_pkg::CTRL_NOP;
        done_fire = 1'b0;
        unique case (state_reg)
            ght_pkg::SEQ_RUN:
            begin
                ctrl      = word;
                done_fire = word.done & out_free;
            end
            default:
            begin
                ctrl = ght_pkg::CTRL_NOP;
            end
        endcase
        busy = (state_reg != ght_pkg::SEQ_IDLE) | flags.clearing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ght_pkg::SEQ_IDLE;
            step_reg  <= ght_pkg::STEP_END;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* rtl/core/ght_datapath.sv */
`timescale 1ns / 1ps

module ght_datapath
#(
    parameter int SLOTS           = 256,
    parameter int GENERATION_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [7:0]                    handle_slot,
    input  logic [15:0]                   handle_generation,
    input  ght_pkg::ctrl_t                ctrl,
    output ght_pkg::dp_flags_t            flags,
    output logic [7:0]                    res_slot,
    output logic [15:0]                   res_generation,
    output logic [7:0]                    res_position,
    output logic                          res_present,
    output logic [1:0]                    res_status,
    output logic [$clog2(SLOTS + 1)-1:0]  live_count
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int GB = GENERATION_BITS;

    logic [GB-1:0] gen_mem   [SLOTS];
    logic          live_mem  [SLOTS];
    logic [CW-1:0] nf_mem    [SLOTS];
    logic [SW-1:0] didx_mem  [SLOTS];
    logic [SW-1:0] owner_mem [SLOTS];

    logic [CW-1:0] free_head_reg;
    logic [CW-1:0] free_head_next;
    logic [CW-1:0] live_count_reg;
    logic [CW-1:0] live_count_next;
    logic          clearing_reg;
    logic          clearing_next;
    logic [CW-1:0] clr_cnt_reg;
    logic [CW-1:0] clr_cnt_next;

    logic [SW-1:0] slot_reg;
    logic          range_ok_reg;
    logic [15:0]   gen_in_reg;
    logic [SW-1:0] hole_reg;
    logic [SW-1:0] mover_reg;

    logic [GB-1:0] gen_rd_reg;
    logic          live_rd_reg;
    logic [CW-1:0] nf_rd_reg;
    logic [SW-1:0] didx_rd_reg;
    logic [SW-1:0] owner_rd_reg;

    logic [7:0]    res_slot_reg;
    logic [15:0]   res_gen_reg;
    logic [7:0]    res_pos_reg;
    logic          res_present_reg;
    logic [1:0]    res_status_reg;

    logic [31:0]   slot_wide;
    logic [31:0]   fh_wide;
    logic [31:0]   lc_wide;
    logic [31:0]   didx_wide;
    logic [31:0]   gen_inc_wide;
    logic [GB-1:0] gen_inc;
    logic [SW-1:0] fh_idx;
    logic [SW-1:0] lc_idx;
    logic [CW-1:0] lc_minus1;
    logic [SW-1:0] last_idx;
    logic [SW-1:0] clr_idx;
    logic [SW-1:0] rd_addr;
    logic          handle_ok;

    logic          gen_we;
    logic [SW-1:0] gen_wa;
    logic [GB-1:0] gen_wd;
    logic          live_we;
    logic [SW-1:0] live_wa;
    logic          live_wd;
    logic          nf_we;
    logic [SW-1:0] nf_wa;
    logic [CW-1:0] nf_wd;
    logic          didx_we;
    logic [SW-1:0] didx_wa;
    logic [SW-1:0] didx_wd;
    logic          owner_we;
    logic [SW-1:0] owner_wa;
    logic [SW-1:0] owner_wd;

    assign slot_wide    = 32'(handle_slot);
    assign fh_idx       = free_head_reg[SW-1:0];
    assign lc_idx       = live_count_reg[SW-1:0];
    assign lc_minus1    = live_count_reg - CW'(1);
    assign last_idx     = lc_minus1[SW-1:0];
    assign clr_idx      = clr_cnt_reg[SW-1:0];
    assign fh_wide      = 32'(fh_idx);
    assign lc_wide      = 32'(live_count_reg);
    assign didx_wide    = 32'(didx_rd_reg);
    assign gen_inc      = gen_rd_reg + GB'(1);
    assign gen_inc_wide = 32'(gen_inc);
    assign rd_addr      = (ctrl.rd_sel == ght_pkg::SA_FREE) ? fh_idx : slot_reg;

    assign handle_ok = range_ok_reg & live_rd_reg
                       & (32'(gen_rd_reg) == 32'(gen_in_reg));

    assign flags.full     = (free_head_reg >= CW'(SLOTS)) | (live_count_reg >= CW'(SLOTS));
    assign flags.bad      = ~handle_ok;
    assign flags.clearing = clearing_reg;

    // Write ports of the slot and dense stores.
    always_comb
    begin
        gen_we   = 1'b0;
        gen_wa   = fh_idx;
        gen_wd   = gen_inc;
        live_we  = 1'b0;
        live_wa  = fh_idx;
        live_wd  = 1'b0;
        nf_we    = 1'b0;
        nf_wa    = slot_reg;
        nf_wd    = free_head_reg;
        didx_we  = 1'b0;
        didx_wa  = fh_idx;
        didx_wd  = lc_idx;
        owner_we = 1'b0;
        owner_wa = lc_idx;
        owner_wd = fh_idx;
        if (clearing_reg)
        begin
            gen_we  = 1'b1;
            gen_wa  = clr_idx;
            gen_wd  = '0;
            live_we = 1'b1;
            live_wa = clr_idx;
            live_wd = 1'b0;
            nf_we   = 1'b1;
            nf_wa   = clr_idx;
            nf_wd   = clr_cnt_reg + CW'(1);
        end
        else
        begin
            unique case (ctrl.op)
                ght_pkg::OP_ADD:
                begin
                    gen_we   = 1'b1;
                    live_we  = 1'b1;
                    live_wd  = 1'b1;
                    didx_we  = 1'b1;
                    owner_we = 1'b1;
                end
                ght_pkg::OP_REM:
                begin
                    live_we  = 1'b1;
                    live_wa  = slot_reg;
                    live_wd  = 1'b0;
                    nf_we    = 1'b1;
                    didx_we  = 1'b1;
                    didx_wa  = mover_reg;
                    didx_wd  = hole_reg;
                    owner_we = 1'b1;
                    owner_wa = hole_reg;
                    owner_wd = mover_reg;
                end
                default:
                begin
                    gen_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[gen_wa] <= gen_wd;
        end
        gen_rd_reg <= gen_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[live_wa] <= live_wd;
        end
        live_rd_reg <= live_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nf_we)
        begin
            nf_mem[nf_wa] <= nf_wd;
        end
        nf_rd_reg <= nf_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (didx_we)
        begin
            didx_mem[didx_wa] <= didx_wd;
        end
        didx_rd_reg <= didx_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_mem[owner_wa] <= owner_wd;
        end
        owner_rd_reg <= owner_mem[last_idx];
    end

    always_comb
    begin
        free_head_next  = free_head_reg;
        live_count_next = live_count_reg;
        clearing_next   = clearing_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + CW'(1);
            if (clr_cnt_reg == CW'(SLOTS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
        else
        begin
            unique case (ctrl.op)
                ght_pkg::OP_ADD:
                begin
                    free_head_next  = nf_rd_reg;
                    live_count_next = live_count_reg + CW'(1);
                end
                ght_pkg::OP_REM:
                begin
                    free_head_next  = CW'(slot_reg);
                    live_count_next = lc_minus1;
                end
                default:
                begin
                    free_head_next = free_head_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            live_count_reg <= '0;
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            free_head_reg  <= free_head_next;
            live_count_reg <= live_count_next;
            clearing_reg   <= clearing_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            slot_reg     <= slot_wide[SW-1:0];
            range_ok_reg <= slot_wide < 32'(SLOTS);
            gen_in_reg   <= handle_generation;
        end
        if (ctrl.op == ght_pkg::OP_TAKE)
        begin
            hole_reg  <= didx_rd_reg;
            mover_reg <= owner_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            res_slot_reg    <= '0;
            res_gen_reg     <= '0;
            res_pos_reg     <= '0;
            res_present_reg <= 1'b0;
            res_status_reg  <= ght_pkg::STATUS_OK;
        end
        else
        begin
            case (ctrl.res_sel)
                ght_pkg::RS_FULL_CHK:
                begin
                    res_status_reg <= flags.full ? ght_pkg::STATUS_FULL : ght_pkg::STATUS_OK;
                end
                ght_pkg::RS_ADD:
                begin
                    res_slot_reg   <= fh_wide[7:0];
                    res_gen_reg    <= gen_inc_wide[15:0];
                    res_pos_reg    <= lc_wide[7:0];
                    res_status_reg <= ght_pkg::STATUS_OK;
                end
                ght_pkg::RS_BAD_CHK:
                begin
                    res_status_reg <= handle_ok ? ght_pkg::STATUS_OK : ght_pkg::STATUS_STALE;
                end
                ght_pkg::RS_REM:
                begin
                    res_present_reg <= 1'b1;
                    res_status_reg  <= ght_pkg::STATUS_OK;
                end
                ght_pkg::RS_QRY:
                begin
                    res_present_reg <= handle_ok;
                    res_pos_reg     <= handle_ok ? didx_wide[7:0] : 8'd0;
                    res_status_reg  <= handle_ok ? ght_pkg::STATUS_OK : ght_pkg::STATUS_STALE;
                end
                default:
                begin
                    res_status_reg <= res_status_reg;
                end
            endcase
        end
    end

    assign res_slot       = res_slot_reg;
    assign res_generation = res_gen_reg;
    assign res_position   = res_pos_reg;
    assign res_present    = res_present_reg;
    assign res_status     = res_status_reg;
    assign live_count     = live_count_reg;

endmodule
